// ----- hdl/irfrtc_pkg.sv -----
// shared types, codes and constants for the indexed register file with real-time clock
`timescale 1ns / 1ps
package irfrtc_pkg;

  localparam int REG_COUNT_DEF = 256;

  // bus and tick request codes
  typedef enum logic [2:0] {
    FN_WR_INDEX = 3'd0,
    FN_RD_INDEX = 3'd1,
    FN_WR_DATA  = 3'd2,
    FN_RD_DATA  = 3'd3,
    FN_TICK     = 3'd4
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  // register addresses with side effects or live read values
  localparam logic [7:0] REG_BTN_EN  = 8'h09;
  localparam logic [7:0] REG_BUTTONS = 8'h0a;
  localparam logic [7:0] REG_PT_LO   = 8'h30;
  localparam logic [7:0] REG_PT_HI   = 8'h31;
  localparam logic [7:0] REG_SEC     = 8'h70;
  localparam logic [7:0] REG_MIN     = 8'h71;
  localparam logic [7:0] REG_HOUR    = 8'h72;
  localparam logic [7:0] REG_DAY_LO  = 8'h73;
  localparam logic [7:0] REG_DAY_HI  = 8'h74;
  localparam logic [7:0] REG_AL_SEC  = 8'h75;
  localparam logic [7:0] REG_AL_MIN  = 8'h76;
  localparam logic [7:0] REG_AL_HOUR = 8'h77;
  localparam logic [7:0] REG_AL_DAY  = 8'h78;
  localparam logic [7:0] REG_IRQ_EN  = 8'h79;
  localparam logic [7:0] REG_IRQ     = 8'h7a;
  localparam logic [7:0] REG_WP      = 8'hc1;

  localparam logic [15:0] PT_RESET = 16'h7200;
  localparam logic [15:0] PT_STEP  = 16'h0100;

  localparam logic [6:0] SEC_LIMIT  = 7'd60;
  localparam logic [6:0] MIN_LIMIT  = 7'd60;
  localparam logic [5:0] HOUR_LIMIT = 6'd24;

  // interrupt flag bit positions
  localparam int IRQ_EN_SEC   = 0;
  localparam int IRQ_EN_ALARM = 1;
  localparam int IRQ_RQ_SEC   = 2;
  localparam int IRQ_RQ_ALARM = 3;

  typedef struct packed {
    logic       rd_step;
    logic       tick;
    logic       wr_en;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic       wp_rd;
  } rtc_ctl_t;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [11:0] day;
    logic [15:0] timer_nxt;
    logic [3:0]  irq_nxt;
    logic        wp;
  } rtc_stat_t;

endpackage

// ----- hdl/irfrtc_mem.sv -----
// register file memory with registered read data and per-entry valid bits
`timescale 1ns / 1ps
module irfrtc_mem #(
  parameter int REG_COUNT = 256,
  parameter int AW        = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic [7:0]    rd_data
);
  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [7:0]           rdata_r;
  logic                 rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : 8'h00;

endmodule

// ----- hdl/irfrtc_rtc.sv -----
// clock counters, alarm, interrupt flags, write protect and pseudo timer
`timescale 1ns / 1ps
module irfrtc_rtc (
  input  logic                 clk,
  input  logic                 rst_n,
  input  irfrtc_pkg::rtc_ctl_t ctl,
  output irfrtc_pkg::rtc_stat_t stat
);
  import irfrtc_pkg::*;

  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [11:0] day_r, day_nxt;
  logic [5:0]  al_sec_r, al_sec_nxt;
  logic [5:0]  al_min_r, al_min_nxt;
  logic [4:0]  al_hour_r, al_hour_nxt;
  logic [4:0]  al_day_r, al_day_nxt;
  logic [3:0]  irq_r, irq_nxt;
  logic        wp_r, wp_nxt;
  logic [15:0] timer_r, timer_nxt;

  always_comb begin
    logic [6:0] s_inc;
    logic [6:0] m_inc;
    logic [5:0] h_inc;
    sec_nxt     = sec_r;
    min_nxt     = min_r;
    hour_nxt    = hour_r;
    day_nxt     = day_r;
    al_sec_nxt  = al_sec_r;
    al_min_nxt  = al_min_r;
    al_hour_nxt = al_hour_r;
    al_day_nxt  = al_day_r;
    irq_nxt     = irq_r;
    wp_nxt      = ctl.wp_rd ? 1'b0 : wp_r;
    timer_nxt   = ctl.rd_step ? timer_r + PT_STEP : timer_r;
    s_inc       = {1'b0, sec_r} + 7'd1;
    m_inc       = {1'b0, min_r} + 7'd1;
    h_inc       = {1'b0, hour_r} + 6'd1;

    if (ctl.tick) begin
      // ripple carry through seconds, minutes, hours and days
      if (s_inc >= SEC_LIMIT) begin
        sec_nxt = '0;
        if (m_inc >= MIN_LIMIT) begin
          min_nxt = '0;
          if (h_inc >= HOUR_LIMIT) begin
            hour_nxt = '0;
            day_nxt  = day_r + 12'd1;
          end else begin
            hour_nxt = h_inc[4:0];
          end
        end else begin
          min_nxt = m_inc[5:0];
        end
      end else begin
        sec_nxt = s_inc[5:0];
      end
      if (irq_r[IRQ_EN_SEC]) begin
        irq_nxt[IRQ_RQ_SEC] = 1'b1;
      end
      if (irq_r[IRQ_EN_ALARM] && sec_nxt == al_sec_r && min_nxt == al_min_r &&
          hour_nxt == al_hour_r && day_nxt[4:0] == al_day_r) begin
        irq_nxt[IRQ_RQ_ALARM] = 1'b1;
      end
    end

    if (ctl.wr_en) begin
      unique case (ctl.addr)
        REG_SEC:     sec_nxt     = ctl.wdata[5:0];
        REG_MIN:     min_nxt     = ctl.wdata[5:0];
        REG_HOUR:    hour_nxt    = ctl.wdata[4:0];
        REG_DAY_LO:  day_nxt     = {day_r[11:8], ctl.wdata};
        REG_DAY_HI:  day_nxt     = {ctl.wdata[3:0], day_r[7:0]};
        REG_AL_SEC:  al_sec_nxt  = ctl.wdata[5:0];
        REG_AL_MIN:  al_min_nxt  = ctl.wdata[5:0];
        REG_AL_HOUR: al_hour_nxt = ctl.wdata[4:0];
        REG_AL_DAY:  al_day_nxt  = ctl.wdata[4:0];
        REG_IRQ_EN:  irq_nxt     = {irq_r[3:2], ctl.wdata[1:0]};
        REG_IRQ: begin
          if (ctl.wdata[1]) begin
            irq_nxt = {2'b00, irq_r[1:0]};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r     <= '0;
      min_r     <= '0;
      hour_r    <= '0;
      day_r     <= '0;
      al_sec_r  <= '0;
      al_min_r  <= '0;
      al_hour_r <= '0;
      al_day_r  <= '0;
      irq_r     <= '0;
      wp_r      <= 1'b1;
      timer_r   <= PT_RESET;
    end else begin
      sec_r     <= sec_nxt;
      min_r     <= min_nxt;
      hour_r    <= hour_nxt;
      day_r     <= day_nxt;
      al_sec_r  <= al_sec_nxt;
      al_min_r  <= al_min_nxt;
      al_hour_r <= al_hour_nxt;
      al_day_r  <= al_day_nxt;
      irq_r     <= irq_nxt;
      wp_r      <= wp_nxt;
      timer_r   <= timer_nxt;
    end
  end

  assign stat.sec       = sec_r;
  assign stat.min       = min_r;
  assign stat.hour      = hour_r;
  assign stat.day       = day_r;
  assign stat.timer_nxt = timer_nxt;
  assign stat.irq_nxt   = irq_nxt;
  assign stat.wp        = wp_r;

endmodule

// ----- hdl/indexed_register_file_with_rtc.sv -----
// top level: index/data register port with register file and real-time clock
// Usage: a request (in_func, in_write_data, in_buttons) is taken at a rising edge
// where start is high and busy is low. in_func selects index write, index read,
// data write, data read or a one-second tick.
// Each request gives exactly one result: out_valid is high for one cycle, the
// cycle right after the request is taken, with out_read_data (zero for writes
// and ticks) and the alarm and one-hertz request bits as they stand after it.
// The receiver cannot stall; a result is gone after its cycle.
// A new request is not taken before the last one has given its result. At accept
// the register file memory read is registered; in the result cycle (ST_RESP) the
// result is presented and all updates are written back. busy is high during the
// result cycle.
// Reset (rst_n low, synchronous) clears the index, counters, alarm and flags,
// sets write protect and loads the pseudo timer with 0x7200; register file
// entries read as zero until written, through valid bits cleared at reset,
// so no clearing pass is needed and requests are taken right after reset.
`timescale 1ns / 1ps
module indexed_register_file_with_rtc #(
  parameter int REG_COUNT = irfrtc_pkg::REG_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_func,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_buttons,
  output logic       out_valid,
  output logic [7:0] out_read_data,
  output logic       out_alarm_request,
  output logic       out_second_request
);
  import irfrtc_pkg::*;

  localparam int AW = $clog2(REG_COUNT);

  state_t     state_r, state_nxt;
  func_t      func_r;
  logic [7:0] wd_r;
  logic [7:0] btn_r;
  logic [7:0] index_r, index_nxt;
  logic       btn_en_r, btn_en_nxt;
  logic       accept;
  logic       step;
  logic [AW-1:0] sel;
  logic [7:0] sel_addr;
  logic [7:0] mem_rdata;
  logic [7:0] rd_data;
  rtc_ctl_t   ctl;
  rtc_stat_t  stat;

  assign accept   = start && (state_r == ST_IDLE);
  assign step     = (state_r == ST_RESP);
  assign sel      = index_r[AW-1:0];
  assign sel_addr = 8'(sel);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_RESP: begin
        busy      = 1'b1;
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= func_t'(in_func);
      wd_r   <= in_write_data;
      btn_r  <= in_buttons;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      index_r  <= '0;
      btn_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      index_r  <= index_nxt;
      btn_en_r <= btn_en_nxt;
    end
  end

  irfrtc_mem #(
    .REG_COUNT (REG_COUNT),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (sel),
    .wr_en   (ctl.wr_en),
    .wr_addr (sel),
    .wr_data (wd_r),
    .rd_data (mem_rdata)
  );

  irfrtc_rtc u_rtc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .stat  (stat)
  );

  // decode the latched request during the result cycle
  always_comb begin
    index_nxt   = index_r;
    btn_en_nxt  = btn_en_r;
    ctl.rd_step = 1'b0;
    ctl.tick    = 1'b0;
    ctl.wr_en   = 1'b0;
    ctl.addr    = sel_addr;
    ctl.wdata   = wd_r;
    ctl.wp_rd   = 1'b0;
    if (step) begin
      unique case (func_r)
        FN_WR_INDEX: index_nxt = wd_r;
        FN_RD_INDEX: ctl.rd_step = 1'b1;
        FN_WR_DATA: begin
          ctl.wr_en = 1'b1;
          if (sel_addr == REG_BTN_EN) begin
            btn_en_nxt = wd_r[0];
          end
        end
        FN_RD_DATA: begin
          ctl.rd_step = 1'b1;
          ctl.wp_rd   = (sel_addr == REG_WP);
        end
        FN_TICK:     ctl.tick = 1'b1;
        default: ;
      endcase
    end
  end

  // live values override the stored byte on data reads
  always_comb begin
    unique case (sel_addr)
      REG_BUTTONS: rd_data = btn_en_r ? btn_r : 8'hff;
      REG_PT_LO:   rd_data = stat.timer_nxt[7:0];
      REG_PT_HI:   rd_data = stat.timer_nxt[15:8];
      REG_SEC:     rd_data = {2'b00, stat.sec};
      REG_MIN:     rd_data = {2'b00, stat.min};
      REG_HOUR:    rd_data = {3'b000, stat.hour};
      REG_DAY_LO:  rd_data = stat.day[7:0];
      REG_DAY_HI:  rd_data = {4'h0, stat.day[11:8]};
      REG_IRQ:     rd_data = {mem_rdata[7:2], stat.irq_nxt[IRQ_RQ_ALARM],
                              stat.irq_nxt[IRQ_RQ_SEC]};
      REG_WP:      rd_data = {mem_rdata[7:1], stat.wp};
      default:     rd_data = mem_rdata;
    endcase
  end

  always_comb begin
    out_read_data = 8'h00;
    case (func_r)
      FN_RD_INDEX: out_read_data = index_r;
      FN_RD_DATA:  out_read_data = rd_data;
      default:     out_read_data = 8'h00;
    endcase
  end

  assign out_alarm_request  = stat.irq_nxt[IRQ_RQ_ALARM];
  assign out_second_request = stat.irq_nxt[IRQ_RQ_SEC];

endmodule

// ----- hdl/irfrtc_chk.sv -----
// port-level checker for the indexed register file with real-time clock
`timescale 1ns / 1ps
module irfrtc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_func,
  input logic       out_valid,
  input logic [7:0] out_read_data
);
  import irfrtc_pkg::*;

  // every taken request yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("no result after accepted request");

  // no result without a request taken the cycle before
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without request");

  // one result per request
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("repeated result");

  // writes, ticks and unused codes read back zero
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_func) != FN_RD_INDEX && $past(in_func) != FN_RD_DATA
      |-> out_read_data == 8'h00)
    else $error("nonzero read data for non-read request");

endmodule

bind indexed_register_file_with_rtc irfrtc_chk u_irfrtc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_read_data (out_read_data)
);

// ----- bench/tb_top.sv -----
// testbench for the index/data register port with register file and real-time clock
`timescale 1ns / 1ps
module tb_top;
  import irfrtc_pkg::*;

  localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FN_SPARE_LAST  = 3'd7;
  localparam int PHASE_REQS  = 550;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic [2:0] f;
    logic [7:0] wd;
    logic [7:0] btn;
    int         idle_pct;
    bit         drain;
  } bus_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       alarm_request;
    logic       second_request;
  } rtc_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_func = '0;
  logic [7:0] in_write_data = '0;
  logic [7:0] in_buttons = '0;
  logic       out_valid;
  logic [7:0] out_read_data;
  logic       out_alarm_request;
  logic       out_second_request;

  indexed_register_file_with_rtc dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_write_data      (in_write_data),
    .in_buttons         (in_buttons),
    .out_valid          (out_valid),
    .out_read_data      (out_read_data),
    .out_alarm_request  (out_alarm_request),
    .out_second_request (out_second_request)
  );

  // predictor state
  logic [7:0]  cur_index = '0;
  logic [7:0]  file_mem [REG_COUNT_DEF];
  logic [15:0] ptimer = PT_RESET;
  logic [5:0]  sec_c = '0;
  logic [5:0]  min_c = '0;
  logic [4:0]  hour_c = '0;
  logic [11:0] day_c = '0;
  logic [5:0]  al_sec = '0;
  logic [5:0]  al_min = '0;
  logic [4:0]  al_hour = '0;
  logic [4:0]  al_day = '0;
  logic [3:0]  irq = '0;
  logic        wprot = 1'b1;

  bus_req_t    req_q [$];
  rtc_result_t pending_results [$];
  int          cur_idle = 0;
  bit          next_drain = 1'b0;
  int          req_count = 0;
  int          err_count = 0;
  int          quiet_cycles = 0;
  bit          took = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // applies one request to the predictor state and returns what the port shows after it
  function automatic rtc_result_t rtc_apply(logic [2:0] f, logic [7:0] wd, logic [7:0] btn);
    rtc_result_t r;
    logic [6:0]  s;
    logic [6:0]  m;
    logic [5:0]  h;
    logic [7:0]  d;
    r = '0;
    case (f)
      FN_WR_INDEX: cur_index = wd;
      FN_RD_INDEX: begin
        ptimer = ptimer + PT_STEP;
        r.read_data = cur_index;
      end
      FN_WR_DATA: begin
        file_mem[cur_index] = wd;
        case (cur_index)
          REG_SEC:     sec_c = wd[5:0];
          REG_MIN:     min_c = wd[5:0];
          REG_HOUR:    hour_c = wd[4:0];
          REG_DAY_LO:  day_c[7:0] = wd;
          REG_DAY_HI:  day_c[11:8] = wd[3:0];
          REG_AL_SEC:  al_sec = wd[5:0];
          REG_AL_MIN:  al_min = wd[5:0];
          REG_AL_HOUR: al_hour = wd[4:0];
          REG_AL_DAY:  al_day = wd[4:0];
          REG_IRQ_EN: begin
            irq[IRQ_EN_SEC] = wd[0];
            irq[IRQ_EN_ALARM] = wd[1];
          end
          REG_IRQ: begin
            if (wd[1]) begin
              irq[IRQ_RQ_SEC] = 1'b0;
              irq[IRQ_RQ_ALARM] = 1'b0;
            end
          end
          default: ;
        endcase
      end
      FN_RD_DATA: begin
        ptimer = ptimer + PT_STEP;
        d = file_mem[cur_index];
        case (cur_index)
          REG_BUTTONS: d = file_mem[REG_BTN_EN][0] ? btn : 8'hff;
          REG_PT_LO:   d = ptimer[7:0];
          REG_PT_HI:   d = ptimer[15:8];
          REG_SEC:     d = {2'b00, sec_c};
          REG_MIN:     d = {2'b00, min_c};
          REG_HOUR:    d = {3'b000, hour_c};
          REG_DAY_LO:  d = day_c[7:0];
          REG_DAY_HI:  d = {4'h0, day_c[11:8]};
          REG_IRQ:     d = {d[7:2], irq[IRQ_RQ_ALARM], irq[IRQ_RQ_SEC]};
          REG_WP: begin
            d[0] = wprot;
            wprot = 1'b0;
          end
          default: ;
        endcase
        r.read_data = d;
      end
      FN_TICK: begin
        s = {1'b0, sec_c} + 7'd1;
        if (s >= SEC_LIMIT) begin
          s = '0;
          m = {1'b0, min_c} + 7'd1;
          if (m >= MIN_LIMIT) begin
            m = '0;
            h = {1'b0, hour_c} + 6'd1;
            if (h >= HOUR_LIMIT) begin
              h = '0;
              day_c = day_c + 12'd1;
            end
            hour_c = h[4:0];
          end
          min_c = m[5:0];
        end
        sec_c = s[5:0];
        if (irq[IRQ_EN_SEC]) irq[IRQ_RQ_SEC] = 1'b1;
        if (irq[IRQ_EN_ALARM] && sec_c == al_sec && min_c == al_min && hour_c == al_hour
            && day_c[4:0] == al_day) irq[IRQ_RQ_ALARM] = 1'b1;
      end
      default: ;
    endcase
    r.alarm_request = irq[IRQ_RQ_ALARM];
    r.second_request = irq[IRQ_RQ_SEC];
    return r;
  endfunction

  task automatic push_req(logic [2:0] f, logic [7:0] wd, logic [7:0] btn);
    bus_req_t q;
    q.f = f;
    q.wd = wd;
    q.btn = btn;
    q.idle_pct = cur_idle;
    q.drain = next_drain;
    next_drain = 1'b0;
    req_q.push_back(q);
    req_count++;
  endtask

  task automatic wr_reg(logic [7:0] addr, logic [7:0] val);
    push_req(FN_WR_INDEX, addr, 8'($urandom));
    push_req(FN_WR_DATA, val, 8'($urandom));
  endtask

  task automatic rd_reg(logic [7:0] addr);
    push_req(FN_WR_INDEX, addr, 8'($urandom));
    push_req(FN_RD_DATA, 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] pick_reg();
    logic [7:0] hot [17];
    hot = '{REG_BTN_EN, REG_BUTTONS, REG_PT_LO, REG_PT_HI, REG_SEC, REG_MIN, REG_HOUR,
            REG_DAY_LO, REG_DAY_HI, REG_AL_SEC, REG_AL_MIN, REG_AL_HOUR, REG_AL_DAY,
            REG_IRQ_EN, REG_IRQ, REG_WP, 8'hff};
    if ($urandom_range(99) < 60) return hot[$urandom_range(16)];
    return 8'($urandom);
  endfunction

  initial begin : stimulus
    int         phase;
    int         kind;
    int         n;
    int         u;
    logic [5:0] s;
    logic [5:0] mi;
    logic [4:0] hr;
    logic [11:0] dy;
    foreach (file_mem[i]) file_mem[i] = '0;

    // directed: reset values, write protect, buttons gate, full rollover into alarm
    cur_idle = 29;
    push_req(FN_RD_INDEX, 8'h00, 8'h00);
    rd_reg(REG_WP);
    push_req(FN_RD_DATA, 8'hff, 8'hff);
    rd_reg(REG_BUTTONS);
    wr_reg(REG_BTN_EN, 8'h01);
    rd_reg(REG_BUTTONS);
    wr_reg(REG_SEC, 8'hff);
    wr_reg(REG_MIN, 8'd59);
    wr_reg(REG_HOUR, 8'd23);
    wr_reg(REG_DAY_HI, 8'hff);
    wr_reg(REG_DAY_LO, 8'hff);
    wr_reg(REG_IRQ_EN, 8'h03);
    push_req(FN_TICK, 8'h00, 8'h00);
    rd_reg(REG_IRQ);
    wr_reg(REG_IRQ, 8'h02);
    for (u = FN_SPARE_FIRST; u <= FN_SPARE_LAST; u++) push_req(3'(u), 8'hff, 8'hff);

    for (phase = 0; phase < 3; phase++) begin
      cur_idle = (phase == 0) ? 29 : (phase == 1) ? 58 : 0;
      next_drain = 1'b1;
      while (req_count < (phase + 1) * PHASE_REQS) begin
        kind = $urandom_range(99);
        if (kind < 30) begin
          push_req(FN_WR_INDEX, pick_reg(), 8'($urandom));
          n = $urandom_range(1, 3);
          repeat (n) push_req($urandom_range(1) ? FN_RD_DATA : FN_WR_DATA,
                              8'($urandom), 8'($urandom));
        end else if (kind < 45) begin
          // clock set with an alarm a few seconds ahead
          s = 6'($urandom_range(58));
          mi = 6'($urandom_range(59));
          hr = 5'($urandom_range(23));
          dy = 12'($urandom);
          wr_reg(REG_SEC, {2'($urandom), s});
          wr_reg(REG_MIN, {2'($urandom), mi});
          wr_reg(REG_HOUR, {3'($urandom), hr});
          wr_reg(REG_DAY_LO, dy[7:0]);
          wr_reg(REG_DAY_HI, {4'($urandom), dy[11:8]});
          wr_reg(REG_AL_SEC, 8'(s + $urandom_range(1, 3)));
          wr_reg(REG_AL_MIN, {2'($urandom), mi});
          wr_reg(REG_AL_HOUR, ($urandom_range(9) == 0) ? 8'($urandom) : {3'($urandom), hr});
          wr_reg(REG_AL_DAY, {3'($urandom), dy[4:0]});
          wr_reg(REG_IRQ_EN, ($urandom_range(3) == 0) ? 8'($urandom) : {6'($urandom), 2'b11});
          n = $urandom_range(1, 4);
          repeat (n) push_req(FN_TICK, 8'($urandom), 8'($urandom));
          rd_reg(REG_IRQ);
        end else if (kind < 55) begin
          // counters written with values from just below their limits up to 255
          wr_reg(REG_SEC, 8'($urandom_range(55, 255)));
          wr_reg(REG_MIN, 8'($urandom_range(58, 255)));
          wr_reg(REG_HOUR, 8'($urandom_range(22, 255)));
          if ($urandom_range(1)) wr_reg(REG_DAY_LO, 8'hff);
          n = $urandom_range(1, 6);
          repeat (n) push_req(FN_TICK, 8'($urandom), 8'($urandom));
          rd_reg(REG_SEC);
          push_req(FN_WR_INDEX, REG_MIN, 8'($urandom));
          push_req(FN_RD_DATA, 8'($urandom), 8'($urandom));
          push_req(FN_WR_INDEX, REG_HOUR, 8'($urandom));
          push_req(FN_RD_DATA, 8'($urandom), 8'($urandom));
          push_req(FN_WR_INDEX, REG_DAY_LO + 8'($urandom_range(1)), 8'($urandom));
          push_req(FN_RD_DATA, 8'($urandom), 8'($urandom));
        end else if (kind < 65) begin
          n = $urandom_range(1, 8);
          repeat (n) push_req(FN_TICK, 8'($urandom), 8'($urandom));
        end else if (kind < 72) begin
          push_req(FN_RD_INDEX, 8'($urandom), 8'($urandom));
        end else if (kind < 80) begin
          wr_reg(REG_IRQ, 8'($urandom));
          rd_reg(REG_IRQ);
        end else if (kind < 88) begin
          // pseudo timer reads of the low or the high byte
          rd_reg(REG_PT_LO + 8'($urandom_range(1)));
          n = $urandom_range(1, 6);
          repeat (n) push_req(FN_RD_DATA, 8'($urandom), 8'($urandom));
        end else begin
          push_req(3'($urandom_range(7)), 8'($urandom), 8'($urandom));
        end
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (req_q.size() == 0 && !start && pending_results.size() == 0);
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // request driver, changes on the falling edge
  always @(negedge clk) begin : driver
    bus_req_t nx;
    if (rst_n && (!start || took)) begin
      if (req_q.size() != 0 && !(req_q[0].drain && pending_results.size() != 0)
          && $urandom_range(99) >= req_q[0].idle_pct) begin
        nx = req_q.pop_front();
        in_func <= nx.f;
        in_write_data <= nx.wd;
        in_buttons <= nx.btn;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result checker and predictor hook, sampled on the rising edge
  always @(posedge clk) begin : monitor
    rtc_result_t want;
    took = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: read_data %0h", out_read_data);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, out_read_data);
            err_count++;
          end
          if (out_alarm_request !== want.alarm_request) begin
            $error("alarm_request: expected %0b, got %0b", want.alarm_request,
                   out_alarm_request);
            err_count++;
          end
          if (out_second_request !== want.second_request) begin
            $error("second_request: expected %0b, got %0b", want.second_request,
                   out_second_request);
            err_count++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        took = 1'b1;
        pending_results.push_back(rtc_apply(in_func, in_write_data, in_buttons));
      end
    end
  end

  // watchdog on cycles with no request taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && busy === 1'b0) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
hdl/irfrtc_pkg.sv
hdl/irfrtc_mem.sv
hdl/irfrtc_rtc.sv
hdl/indexed_register_file_with_rtc.sv
hdl/irfrtc_chk.sv
bench/tb_top.sv
